>>> hdl/vfpb_pkg.sv
// ----------------------------------------------------------------------------
// vfpb_pkg
// Shared types and constants for the video fade / crossfade pixel blend.
// ----------------------------------------------------------------------------
package vfpb_pkg;

  // frame counter width
  localparam int FRAME_BITS = 20;

  // weight numerator 2550*n + 4*d stays below 2^(FRAME_BITS+12)
  localparam int NUM_W      = FRAME_BITS + 12;
  localparam int WEIGHT_W   = 8;
  localparam int DIV_STEPS  = WEIGHT_W;
  localparam int SAMPLE_W   = 8;
  localparam int CFG_IDX_W  = 4;

  // weight = floor((2550*n + 4*d) / (10*d))
  localparam logic [11:0] WEIGHT_SCALE = 12'd2550;
  localparam logic [3:0]  DIV_SCALE    = 4'd10;
  localparam int          BIAS_SHIFT   = 2;

  localparam logic [WEIGHT_W-1:0] MAX_GAIN     = 8'd255;
  localparam logic [SAMPLE_W:0]   CHROMA_ZERO  = 9'd128;
  localparam logic signed [17:0]  CHROMA_BIAS  = 18'sd32768;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FRAME   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_BLACK    = 4'd3;

  // per-sample payload that rides along the pipeline
  typedef struct packed {
    logic                pass;
    logic                is_chroma;
    logic [SAMPLE_W-1:0] src_smp;
    logic [SAMPLE_W-1:0] end_smp;
  } item_t;

endpackage

>>> hdl/vfpb_div_stage.sv
// ----------------------------------------------------------------------------
// vfpb_div_stage
// One restoring division step: produces one weight bit per stage.
// ----------------------------------------------------------------------------
module vfpb_div_stage
  import vfpb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [NUM_W-1:0]    divisor,
  input  logic                in_valid,
  input  item_t               in_item,
  input  logic [NUM_W-1:0]    in_rem,
  input  logic [WEIGHT_W-1:0] in_quot,
  output logic                out_valid,
  output item_t               out_item,
  output logic [NUM_W-1:0]    out_rem,
  output logic [WEIGHT_W-1:0] out_quot
);

  logic                valid_r;
  item_t               item_r;
  logic [NUM_W-1:0]    rem_r;
  logic [WEIGHT_W-1:0] quot_r;
  logic                qbit;
  logic [NUM_W-1:0]    diff;
  logic [NUM_W-1:0]    rem_nxt;
  logic [WEIGHT_W-1:0] quot_nxt;

  // compare and subtract against the top-aligned divisor, then shift
  always_comb begin
    qbit     = (in_rem >= divisor);
    diff     = qbit ? (in_rem - divisor) : in_rem;
    rem_nxt  = {diff[NUM_W-2:0], 1'b0};
    quot_nxt = {in_quot[WEIGHT_W-2:0], qbit};
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= in_item;
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;
  assign out_rem   = rem_r;
  assign out_quot  = quot_r;

endmodule

>>> hdl/vfpb_blend.sv
// ----------------------------------------------------------------------------
// vfpb_blend
// Gain selection, sample products and final sum into the output register.
// ----------------------------------------------------------------------------
module vfpb_blend
  import vfpb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                fade_in,
  input  logic                to_black,
  input  logic                in_valid,
  input  item_t               in_item,
  input  logic [WEIGHT_W-1:0] in_weight,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] out_sample
);

  logic [WEIGHT_W-1:0]   gain_a;
  logic [WEIGHT_W-1:0]   gain_b;
  logic signed [8:0]     s_val;
  logic signed [8:0]     e_val;
  logic signed [17:0]    prod_a;
  logic signed [17:0]    prod_b;

  logic                  mul_valid_r;
  item_t                 mul_item_r;
  logic signed [17:0]    prod_a_r;
  logic signed [17:0]    prod_b_r;

  logic signed [17:0]    acc;
  logic [SAMPLE_W-1:0]   smp_nxt;
  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_sample_r;

  // gains and samples, chroma centered on 128
  always_comb begin
    gain_a = fade_in ? in_weight : (MAX_GAIN - in_weight);
    gain_b = MAX_GAIN - gain_a;
    if (in_item.is_chroma) begin
      s_val = $signed({1'b0, in_item.src_smp} - CHROMA_ZERO);
      e_val = $signed({1'b0, in_item.end_smp} - CHROMA_ZERO);
    end else begin
      s_val = $signed({1'b0, in_item.src_smp});
      e_val = $signed({1'b0, in_item.end_smp});
    end
    prod_a = s_val * $signed({1'b0, gain_a});
    prod_b = to_black ? 18'sd0 : (e_val * $signed({1'b0, gain_b}));
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (adv) begin
      mul_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_item_r <= in_item;
      prod_a_r   <= prod_a;
      prod_b_r   <= prod_b;
    end
  end

  // sum, bias and pass-through select
  always_comb begin
    acc = prod_a_r + prod_b_r + (mul_item_r.is_chroma ? CHROMA_BIAS : 18'sd0);
    smp_nxt = mul_item_r.pass ? mul_item_r.src_smp : acc[15:8];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample_r <= smp_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

>>> hdl/video_fade_pixel_blend.sv
// ----------------------------------------------------------------------------
// video_fade_pixel_blend
// Fade to black or crossfade of 8-bit YUV samples over a frame interval.
// ----------------------------------------------------------------------------
// pipeline: stage 0, stage 1, the divider stages, the product register and the output register
// throughput: one sample per cycle; the 8-stage restoring divider for the
//   weight takes one quotient bit per stage and is fully pipelined
// the whole pipeline holds while the output request waits on out_ready
// reset: synchronous active-low rst_n clears valid bits and config registers
module video_fade_pixel_blend
  import vfpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write request
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [FRAME_BITS-1:0] cfg_data,
  // input sample request
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FRAME_BITS-1:0] in_frame_number,
  input  logic                  in_is_chroma,
  input  logic [SAMPLE_W-1:0]   in_src_sample,
  input  logic [SAMPLE_W-1:0]   in_end_sample,
  // result request
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_sample
);

  logic [FRAME_BITS-1:0] start_frame_r;
  logic [FRAME_BITS-1:0] end_frame_r;
  logic                  fade_in_r;
  logic                  to_black_r;

  logic                  adv;
  logic [FRAME_BITS-1:0] span;
  logic [NUM_W-1:0]      divisor_r;

  logic                  in_pass;
  item_t                 in_item;

  logic                  s0_valid_r;
  item_t                 s0_item_r;
  logic [FRAME_BITS-1:0] s0_n_r;

  logic                  s1_valid_r;
  item_t                 s1_item_r;
  logic [NUM_W-1:0]      s1_rem_r;
  logic [NUM_W-1:0]      num_nxt;

  logic                  dv_valid [0:DIV_STEPS];
  item_t                 dv_item  [0:DIV_STEPS];
  logic [NUM_W-1:0]      dv_rem   [0:DIV_STEPS];
  logic [WEIGHT_W-1:0]   dv_quot  [0:DIV_STEPS];

  // pipeline moves whenever the output register is free or being taken
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_frame_r <= '0;
      end_frame_r   <= '0;
      fade_in_r     <= 1'b0;
      to_black_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_FRAME: start_frame_r <= cfg_data;
        CFG_END_FRAME:   end_frame_r   <= cfg_data;
        CFG_FADE_IN:     fade_in_r     <= cfg_data[0];
        CFG_TO_BLACK:    to_black_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // divisor 10*d aligned to the top quotient bit
  assign span = end_frame_r - start_frame_r;

  always_ff @(posedge clk) begin
    divisor_r <= (NUM_W'(span) * NUM_W'(DIV_SCALE)) << (WEIGHT_W - 1);
  end

  // interval check on the incoming sample
  always_comb begin
    in_pass = (in_frame_number > end_frame_r) || (in_frame_number < start_frame_r) ||
              (start_frame_r == end_frame_r);
    in_item.pass      = in_pass;
    in_item.is_chroma = in_is_chroma;
    in_item.src_smp   = in_src_sample;
    in_item.end_smp   = in_end_sample;
  end

  // stage 0: register sample and frame offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item_r <= in_item;
      s0_n_r    <= in_frame_number - start_frame_r;
    end
  end

  // stage 1: weight numerator 2550*n + 4*d
  assign num_nxt = (NUM_W'(s0_n_r) * NUM_W'(WEIGHT_SCALE)) +
                   (NUM_W'(span) << BIAS_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= s0_item_r;
      s1_rem_r  <= num_nxt;
    end
  end

  // divider chain, one weight bit per stage
  assign dv_valid[0] = s1_valid_r;
  assign dv_item[0]  = s1_item_r;
  assign dv_rem[0]   = s1_rem_r;
  assign dv_quot[0]  = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    vfpb_div_stage u_div_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .divisor   (divisor_r),
      .in_valid  (dv_valid[k]),
      .in_item   (dv_item[k]),
      .in_rem    (dv_rem[k]),
      .in_quot   (dv_quot[k]),
      .out_valid (dv_valid[k+1]),
      .out_item  (dv_item[k+1]),
      .out_rem   (dv_rem[k+1]),
      .out_quot  (dv_quot[k+1])
    );
  end

  // gain, products and output register
  vfpb_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .fade_in    (fade_in_r),
    .to_black   (to_black_r),
    .in_valid   (dv_valid[DIV_STEPS]),
    .in_item    (dv_item[DIV_STEPS]),
    .in_weight  (dv_quot[DIV_STEPS]),
    .out_valid  (out_valid),
    .out_sample (out_sample)
  );

endmodule

>>> sim/video_fade_pixel_blend_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_fade_pixel_blend_tb
// Self-checking bench for the fade / crossfade pixel blend. A short table of
// directed requests covers pass-through, the ends of the fade and the register
// corners; then random phases reprogram the fade window and stream samples
// with random gaps and receiver stalls. Every result is checked in order
// against a local blend predictor or a value fixed in the table.
// ----------------------------------------------------------------------------
module video_fade_pixel_blend_tb;
  import vfpb_pkg::*;

  localparam logic [FRAME_BITS-1:0] FRAME_MAX  = '1;
  localparam int unsigned           FRAME_TOP  = 32'(FRAME_MAX);
  localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED = '1;
  localparam int NUM_ROWS     = 27;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 100;
  localparam int LONG_HOLD    = 80;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  // one directed step: a register write or a sample request
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [FRAME_BITS-1:0] value;
    logic                  chroma;
    logic [SAMPLE_W-1:0]   src;
    logic [SAMPLE_W-1:0]   tgt;
    logic                  known;
    logic [SAMPLE_W-1:0]   known_sample;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [FRAME_BITS-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [FRAME_BITS-1:0] in_frame_number;
  logic                  in_is_chroma;
  logic [SAMPLE_W-1:0]   in_src_sample;
  logic [SAMPLE_W-1:0]   in_end_sample;
  logic                  out_valid;
  logic                  out_ready;
  logic [SAMPLE_W-1:0]   out_sample;

  // predictor copy of the fade registers
  logic [FRAME_BITS-1:0] fade_start = '0;
  logic [FRAME_BITS-1:0] fade_end   = '0;
  logic                  fade_in_q  = 1'b0;
  logic                  to_black_q = 1'b0;

  logic [SAMPLE_W-1:0] expected_samples[$];
  logic [SAMPLE_W-1:0] head_sample;
  logic                fixed_valid;
  logic [SAMPLE_W-1:0] fixed_sample;
  int                  mismatch_count = 0;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req  = 1'b0;

  dir_row_t dir_rows [NUM_ROWS] = '{
    // reset state: start equals end, everything passes through
    '{ROW_SAMPLE, CFG_UNUSED, 20'd0, 1'b0, 8'h5A, 8'hC3, 1'b1, 8'h5A},
    '{ROW_SAMPLE, CFG_UNUSED, FRAME_MAX, 1'b1, 8'hFF, 8'h00, 1'b1, 8'hFF},
    // fade out to black over frames 10..20
    '{ROW_CFG, CFG_START_FRAME, 20'd10, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
    '{ROW_CFG, CFG_END_FRAME, 20'd20, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
    '{ROW_CFG, CFG_TO_BLACK, 20'd1, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd9, 1'b0, 8'd77, 8'd3, 1'b1, 8'd77},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd21, 1'b1, 8'd200, 8'd10, 1'b1, 8'd200},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd10, 1'b0, 8'hFF, 8'h00, 1'b0, 8'h00},
    // end of a fade out: luma black, chroma mid-gray
    '{ROW_SAMPLE, CFG_UNUSED, 20'd20, 1'b0, 8'hFF, 8'hFF, 1'b1, 8'd0},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd20, 1'b1, 8'd200, 8'h00, 1'b1, 8'd128},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd10, 1'b1, 8'h00, 8'hFF, 1'b0, 8'h00},
    // end sample is ignored in fade to black
    '{ROW_SAMPLE, CFG_UNUSED, 20'd15, 1'b1, 8'hFF, 8'h00, 1'b0, 8'h00},
    // crossfade, fade in
    '{ROW_CFG, CFG_FADE_IN, 20'd1, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
    '{ROW_CFG, CFG_TO_BLACK, 20'd0, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd10, 1'b0, 8'hFF, 8'h00, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd20, 1'b0, 8'h00, 8'hFF, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd17, 1'b1, 8'h00, 8'hFF, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd13, 1'b1, 8'hFF, 8'h00, 1'b0, 8'h00},
    // start after end: every frame passes through
    '{ROW_CFG, CFG_START_FRAME, 20'd30, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd25, 1'b0, 8'd33, 8'd250, 1'b1, 8'd33},
    // widest window
    '{ROW_CFG, CFG_START_FRAME, 20'd0, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
    '{ROW_CFG, CFG_END_FRAME, FRAME_MAX, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_UNUSED, FRAME_MAX, 1'b0, 8'd128, 8'd64, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_UNUSED, 20'h80000, 1'b1, 8'hFF, 8'h01, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_UNUSED, 20'd0, 1'b0, 8'h00, 8'hFF, 1'b0, 8'h00},
    // write to an unknown register changes nothing
    '{ROW_CFG, CFG_UNUSED, FRAME_MAX, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
    '{ROW_SAMPLE, CFG_UNUSED, 20'h7FFFF, 1'b1, 8'h80, 8'h80, 1'b0, 8'h00}
  };

  video_fade_pixel_blend u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_frame_number (in_frame_number),
    .in_is_chroma    (in_is_chroma),
    .in_src_sample   (in_src_sample),
    .in_end_sample   (in_end_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // blended sample for the current fade registers
  function automatic logic [SAMPLE_W-1:0] blend_sample(
    input logic [FRAME_BITS-1:0] frame,
    input logic                  chroma,
    input logic [SAMPLE_W-1:0]   src,
    input logic [SAMPLE_W-1:0]   tgt
  );
    longint unsigned num;
    longint unsigned den;
    longint unsigned weight;
    int gain_a;
    int gain_b;
    int acc;
    if (frame > fade_end || frame < fade_start || fade_start == fade_end)
      return src;
    num = frame - fade_start;
    den = fade_end - fade_start;
    // floor(255*n/d + 0.4) in exact integer form
    weight = (64'd2550 * num + 64'd4 * den) / (64'd10 * den);
    if (weight > 64'd255)
      weight = 64'd255;
    gain_a = fade_in_q ? int'(weight) : 255 - int'(weight);
    gain_b = 255 - gain_a;
    if (to_black_q) begin
      if (chroma)
        acc = 32768 + (int'(src) - 128) * gain_a;
      else
        acc = int'(src) * gain_a;
    end else begin
      if (chroma)
        acc = 32768 + (int'(src) - 128) * gain_a + (int'(tgt) - 128) * gain_b;
      else
        acc = int'(src) * gain_a + int'(tgt) * gain_b;
    end
    return acc[15:8];
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // offer one sample request and hold it until accepted
  task automatic send_sample(
    input logic [FRAME_BITS-1:0] frame,
    input logic                  chroma,
    input logic [SAMPLE_W-1:0]   src,
    input logic [SAMPLE_W-1:0]   tgt,
    input logic                  fixed,
    input logic [SAMPLE_W-1:0]   fixed_val
  );
    int unsigned gap;
    @(negedge clk);
    in_valid        = 1'b1;
    in_frame_number = frame;
    in_is_chroma    = chroma;
    in_src_sample   = src;
    in_end_sample   = tgt;
    fixed_valid     = fixed;
    fixed_sample    = fixed_val;
    do @(posedge clk); while (!in_ready);
    gap = tx_steady ? 0 : idle_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_valid    = 1'b0;
    fixed_valid = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  // register write request, mirrored into the predictor on accept
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_FRAME: fade_start = data;
      CFG_END_FRAME:   fade_end   = data;
      CFG_FADE_IN:     fade_in_q  = data[0];
      CFG_TO_BLACK:    to_black_q = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // flag register write with random upper bits
  function automatic logic [FRAME_BITS-1:0] flag_word(input logic flag);
    logic [FRAME_BITS-1:0] w;
    w = FRAME_BITS'($urandom);
    w[0] = flag;
    return w;
  endfunction

  // receiver: random stalls, steady stretches, and long hold-offs on request
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left == 0 && stall_left == 0 && !rx_steady && $urandom_range(0, 3) == 0)
        stall_left = idle_gap();
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // queue predictions on accepted requests, check results in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_samples.push_back(fixed_valid ? fixed_sample :
          blend_sample(in_frame_number, in_is_chroma, in_src_sample, in_end_sample));
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] result %0d with nothing expected", $realtime, out_sample);
        end else begin
          head_sample = expected_samples.pop_front();
          if (out_sample !== head_sample) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("[%0t] out_sample expected %0d got %0d",
                       $realtime, head_sample, out_sample);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned span;
    int unsigned start_v;
    int unsigned end_v;
    int unsigned lo_f;
    int unsigned hi_f;
    logic [FRAME_BITS-1:0] frame_v;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_frame_number = '0;
    in_is_chroma    = 1'b0;
    in_src_sample   = '0;
    in_end_sample   = '0;
    fixed_valid     = 1'b0;
    fixed_sample    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_sample(dir_rows[i].value, dir_rows[i].chroma, dir_rows[i].src,
                    dir_rows[i].tgt, dir_rows[i].known, dir_rows[i].known_sample);
      end
    end

    // random phases, each with its own fade window
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase % 6)
        0: begin
          start_v = 0;
          end_v   = FRAME_TOP;
        end
        1: begin
          start_v = (phase == 1) ? FRAME_TOP : $urandom_range(0, FRAME_TOP);
          end_v   = start_v;
        end
        2: begin
          end_v   = $urandom_range(0, FRAME_TOP - 300);
          start_v = end_v + $urandom_range(1, 300);
        end
        default: begin
          span    = $urandom_range(1, 300);
          start_v = $urandom_range(0, FRAME_TOP - span);
          end_v   = start_v + span;
        end
      endcase
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(32'(CFG_TO_BLACK) + 1, 32'(CFG_UNUSED))),
                  FRAME_BITS'($urandom));
      write_reg(CFG_START_FRAME, FRAME_BITS'(start_v));
      write_reg(CFG_END_FRAME, FRAME_BITS'(end_v));
      write_reg(CFG_FADE_IN, flag_word(1'((phase >> 1) & 1)));
      write_reg(CFG_TO_BLACK, flag_word(1'(phase & 1)));

      // frames mostly around the window, some anywhere
      lo_f = (start_v < end_v) ? start_v : end_v;
      hi_f = (start_v < end_v) ? end_v : start_v;
      lo_f = (lo_f > 2) ? lo_f - 2 : 0;
      hi_f = (hi_f < FRAME_TOP - 2) ? hi_f + 2 : FRAME_TOP;

      tx_steady = (phase % 4 == 1);
      rx_steady = (phase % 4 == 2);
      // long receiver hold-off while requests keep coming
      if (phase % 3 == 0)
        hold_req = 1'b1;

      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0)
          frame_v = FRAME_BITS'($urandom);
        else
          frame_v = FRAME_BITS'($urandom_range(lo_f, hi_f));
        send_sample(frame_v, 1'($urandom), 8'($urandom), 8'($urandom), 1'b0, 8'h00);
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0) begin
      mismatch_count += expected_samples.size();
      $display("%0d results never arrived", expected_samples.size());
    end
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
hdl/vfpb_pkg.sv
hdl/vfpb_div_stage.sv
hdl/vfpb_blend.sv
hdl/video_fade_pixel_blend.sv
sim/video_fade_pixel_blend_tb.sv
